/* design/bve_pkg.sv */
// Shared constants, codes, control structures and mask function of the bit vector engine.
package bve_pkg;

    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = 16;
    localparam int BOUND_BITS = WORD_BITS * WORD_COUNT;

    localparam int BPOS_W = $clog2(WORD_BITS);
    localparam int WIDX_W = $clog2(WORD_COUNT);
    localparam int SRC_W  = WIDX_W + 3;

    localparam int OP_W   = 4;
    localparam int BIDX_W = 10;
    localparam int LEN_W  = 11;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE    = 4'd0,
        OP_FLIP     = 4'd1,
        OP_TEST     = 4'd2,
        OP_SET_ALL  = 4'd3,
        OP_CLR_ALL  = 4'd4,
        OP_FLIP_ALL = 4'd5,
        OP_SHIFT    = 4'd6,
        OP_APPEND   = 4'd7,
        OP_RESIZE   = 4'd8,
        OP_OR       = 4'd9,
        OP_AND      = 4'd10,
        OP_XOR      = 4'd11,
        OP_READ     = 4'd12
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_SAT   = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MODIFY,
        S_SWEEP,
        S_PRIME,
        S_SHIFT,
        S_RESULT
    } state_t;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_WRITE,
        ALU_FLIP,
        ALU_SET,
        ALU_CLEAR,
        ALU_INVERT,
        ALU_TRIM,
        ALU_SHIFT,
        ALU_OR,
        ALU_AND,
        ALU_XOR
    } alu_op_t;

    typedef struct packed {
        logic              wr_en;
        logic [WIDX_W-1:0] wr_addr;
        logic [WIDX_W-1:0] rd_addr;
    } store_ctl_t;

    typedef struct packed {
        alu_op_t              aop;
        logic [WIDX_W-1:0]    word_idx;
        logic [LEN_W-1:0]     len;
        logic [BPOS_W-1:0]    bit_pos;
        logic                 bit_val;
        logic [BPOS_W-1:0]    shamt;
        logic                 src_ok;
        logic                 hold_load;
        logic [WORD_BITS-1:0] operand;
    } alu_ctl_t;

    typedef struct packed {
        logic              load;
        logic              bit_out;
        logic [LEN_W-1:0]  length;
        logic [STAT_W-1:0] status;
        logic              word_ok;
    } res_t;

    // bits of word k whose position lies below len
    function automatic logic [WORD_BITS-1:0] live_mask(logic [WIDX_W-1:0] k,
                                                      logic [LEN_W-1:0]  len);
        logic [LEN_W-1:0] base;
        logic [LEN_W-1:0] diff;
        base = LEN_W'(k) << BPOS_W;
        diff = len - base;
        if (len <= base)
            return '0;
        if (diff >= LEN_W'(WORD_BITS))
            return '1;
        return ({{(WORD_BITS-1){1'b0}}, 1'b1} << diff[BPOS_W-1:0]) - WORD_BITS'(1);
    endfunction

endpackage

/* design/bve_req_if.sv */
// Request channel: one operation per beat.
interface bve_req_if
    import bve_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [BIDX_W-1:0]    bit_index;
    logic                 bit_value;
    logic [LEN_W-1:0]     amount;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_value;
    logic [LEN_W-1:0]     other_length;

    modport source (
        output valid, op, bit_index, bit_value, amount, word_index, word_value,
               other_length,
        input  ready
    );

    modport sink (
        input  valid, op, bit_index, bit_value, amount, word_index, word_value,
               other_length,
        output ready
    );
endinterface

/* design/bve_rsp_if.sv */
// Response channel: one result per beat.
interface bve_rsp_if
    import bve_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 bit_out;
    logic [WORD_BITS-1:0] word_out;
    logic [LEN_W-1:0]     length_out;
    logic [STAT_W-1:0]    status;

    modport source (
        output valid, bit_out, word_out, length_out, status,
        input  ready
    );

    modport sink (
        input  valid, bit_out, word_out, length_out, status,
        output ready
    );
endinterface

/* design/bve_store.sv */
// Word store of the bit vector: one read port, one write port.
module bve_store
    import bve_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  store_ctl_t           ctl,
    input  logic [WORD_BITS-1:0] wr_data,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] words_reg [WORD_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WORD_COUNT; k++)
            begin
                words_reg[k] <= '0;
            end
        end
        else if (ctl.wr_en)
        begin
            words_reg[ctl.wr_addr] <= wr_data;
        end
    end

    assign rd_data = words_reg[ctl.rd_addr];

endmodule

/* design/bve_alu.sv */
// Shared word unit: bit update, masking, logic ops and the shift funnel with its carry word.
module bve_alu
    import bve_pkg::*;
(
    input  logic                 clk,
    input  alu_ctl_t             ctl,
    input  logic [WORD_BITS-1:0] rd_word,
    output logic [WORD_BITS-1:0] wr_word,
    output logic                 rd_bit
);

    logic [WORD_BITS-1:0] hold_reg;
    logic [WORD_BITS-1:0] hold_next;
    logic [WORD_BITS-1:0] live;
    logic [WORD_BITS-1:0] cur;
    logic [WORD_BITS-1:0] onehot;
    logic [WORD_BITS-1:0] spill;
    logic [BPOS_W:0]      rshift;

    assign live   = live_mask(ctl.word_idx, ctl.len);
    assign cur    = ctl.src_ok ? rd_word : '0;
    assign onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << ctl.bit_pos;
    assign rshift = (BPOS_W+1)'(WORD_BITS) - {1'b0, ctl.shamt};
    assign spill  = (ctl.shamt == '0) ? '0 : (cur >> rshift);
    assign rd_bit = rd_word[ctl.bit_pos];

    always_comb
    begin
        unique case (ctl.aop)
            ALU_WRITE:  wr_word = ctl.bit_val ? (rd_word | onehot) : (rd_word & ~onehot);
            ALU_FLIP:   wr_word = rd_word ^ onehot;
            ALU_SET:    wr_word = live;
            ALU_CLEAR:  wr_word = '0;
            ALU_INVERT: wr_word = ~rd_word & live;
            ALU_TRIM:   wr_word = rd_word & live;
            ALU_SHIFT:  wr_word = ((hold_reg << ctl.shamt) | spill) & live;
            ALU_OR:     wr_word = rd_word | (ctl.operand & live);
            ALU_AND:    wr_word = rd_word & (ctl.operand | ~live);
            ALU_XOR:    wr_word = rd_word ^ (ctl.operand & live);
            default:    wr_word = rd_word;
        endcase
    end

    assign hold_next = ctl.hold_load ? cur : hold_reg;

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

/* design/bve_seq.sv */
// Sequencer: takes a request beat, walks the word store through the shared unit, forms the result.
module bve_seq
    import bve_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bve_req_if.sink       req,
    input  logic          out_free,
    input  logic          rd_bit,
    output store_ctl_t    sctl,
    output alu_ctl_t      actl,
    output res_t          res
);

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [BPOS_W-1:0]    bpos_reg, bpos_next;
    logic                 bval_reg, bval_next;
    logic [WIDX_W-1:0]    addr_reg, addr_next;
    logic [LEN_W-1:0]     amount_reg, amount_next;
    logic [WIDX_W-1:0]    widx_reg, widx_next;
    logic [WORD_BITS-1:0] wval_reg, wval_next;
    logic [LEN_W-1:0]     minlen_reg, minlen_next;
    logic [WIDX_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]     length_reg, length_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic                 bit_out_reg, bit_out_next;

    logic                 accept;
    logic                 bit_oob;
    logic                 widx_ok;
    logic                 word_bad;
    logic                 full;
    logic [LEN_W:0]       grown;
    logic [SRC_W-1:0]     src;
    logic                 word_op;

    assign accept   = req.valid && req.ready;
    assign bit_oob  = LEN_W'(req.bit_index) >= length_reg;
    assign widx_ok  = {1'b0, req.word_index} < (WIDX_W+1)'(WORD_COUNT);
    assign word_bad = !widx_ok || ((LEN_W'(req.word_index) << BPOS_W) >= length_reg);
    assign full     = length_reg >= LEN_W'(BOUND_BITS);
    assign grown    = {1'b0, length_reg} + {1'b0, req.amount};
    assign src      = SRC_W'(cnt_reg) - SRC_W'(amount_reg[LEN_W-1:BPOS_W])
                      - SRC_W'(state_reg == S_SHIFT);
    assign word_op  = (op_reg == OP_OR) || (op_reg == OP_AND) || (op_reg == OP_XOR);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.op)
                        OP_WRITE, OP_FLIP, OP_TEST:
                            state_next = bit_oob ? S_RESULT : S_MODIFY;
                        OP_SET_ALL, OP_CLR_ALL, OP_FLIP_ALL, OP_RESIZE:
                            state_next = S_SWEEP;
                        OP_SHIFT:
                            state_next = S_PRIME;
                        OP_APPEND:
                            state_next = full ? S_RESULT : S_MODIFY;
                        OP_OR, OP_AND, OP_XOR:
                            state_next = word_bad ? S_RESULT : S_MODIFY;
                        default:
                            state_next = S_RESULT;
                    endcase
                end
            end
            S_MODIFY:
                state_next = S_RESULT;
            S_SWEEP:
            begin
                if (cnt_reg == WIDX_W'(WORD_COUNT-1))
                    state_next = S_RESULT;
            end
            S_PRIME:
                state_next = S_SHIFT;
            S_SHIFT:
            begin
                if (cnt_reg == '0)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready      = (state_reg == S_IDLE);
        sctl.wr_en     = 1'b0;
        sctl.wr_addr   = cnt_reg;
        sctl.rd_addr   = widx_reg;
        actl.aop       = ALU_NONE;
        actl.word_idx  = cnt_reg;
        actl.len       = length_reg;
        actl.bit_pos   = bpos_reg;
        actl.bit_val   = bval_reg;
        actl.shamt     = amount_reg[BPOS_W-1:0];
        actl.src_ok    = 1'b1;
        actl.hold_load = 1'b0;
        actl.operand   = wval_reg;
        res.load       = (state_reg == S_RESULT) && out_free;
        res.bit_out    = bit_out_reg;
        res.length     = length_reg;
        res.status     = status_reg;
        res.word_ok    = {1'b0, widx_reg} < (WIDX_W+1)'(WORD_COUNT);
        unique case (state_reg)
            S_MODIFY:
            begin
                sctl.rd_addr  = addr_reg;
                sctl.wr_addr  = addr_reg;
                sctl.wr_en    = (op_reg != OP_TEST);
                actl.word_idx = addr_reg;
                if (word_op)
                    actl.len = minlen_reg;
                priority case (op_reg)
                    OP_WRITE, OP_APPEND: actl.aop = ALU_WRITE;
                    OP_FLIP:             actl.aop = ALU_FLIP;
                    OP_OR:               actl.aop = ALU_OR;
                    OP_AND:              actl.aop = ALU_AND;
                    OP_XOR:              actl.aop = ALU_XOR;
                    default:             actl.aop = ALU_NONE;
                endcase
            end
            S_SWEEP:
            begin
                sctl.rd_addr = cnt_reg;
                sctl.wr_en   = 1'b1;
                priority case (op_reg)
                    OP_SET_ALL:  actl.aop = ALU_SET;
                    OP_CLR_ALL:  actl.aop = ALU_CLEAR;
                    OP_FLIP_ALL: actl.aop = ALU_INVERT;
                    default:     actl.aop = ALU_TRIM;
                endcase
            end
            S_PRIME:
            begin
                sctl.rd_addr   = src[WIDX_W-1:0];
                actl.src_ok    = !src[SRC_W-1];
                actl.hold_load = 1'b1;
            end
            S_SHIFT:
            begin
                sctl.rd_addr   = src[WIDX_W-1:0];
                sctl.wr_en     = 1'b1;
                actl.aop       = ALU_SHIFT;
                actl.src_ok    = !src[SRC_W-1];
                actl.hold_load = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // captured item, counter, length and status
    always_comb
    begin
        op_next      = op_reg;
        bpos_next    = bpos_reg;
        bval_next    = bval_reg;
        addr_next    = addr_reg;
        amount_next  = amount_reg;
        widx_next    = widx_reg;
        wval_next    = wval_reg;
        minlen_next  = minlen_reg;
        cnt_next     = cnt_reg;
        length_next  = length_reg;
        status_next  = status_reg;
        bit_out_next = bit_out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = req.op;
                    bval_next    = req.bit_value;
                    amount_next  = req.amount;
                    widx_next    = req.word_index;
                    wval_next    = req.word_value;
                    minlen_next  = (length_reg < req.other_length) ? length_reg
                                                                   : req.other_length;
                    bpos_next    = req.bit_index[BPOS_W-1:0];
                    addr_next    = req.bit_index[BPOS_W +: WIDX_W];
                    cnt_next     = '0;
                    status_next  = STAT_OK;
                    bit_out_next = 1'b0;
                    unique case (req.op)
                        OP_WRITE, OP_FLIP, OP_TEST:
                        begin
                            if (bit_oob)
                                status_next = STAT_RANGE;
                        end
                        OP_SHIFT:
                        begin
                            cnt_next = WIDX_W'(WORD_COUNT-1);
                            if (grown > (LEN_W+1)'(BOUND_BITS))
                            begin
                                length_next = LEN_W'(BOUND_BITS);
                                status_next = STAT_SAT;
                            end
                            else
                            begin
                                length_next = grown[LEN_W-1:0];
                            end
                        end
                        OP_APPEND:
                        begin
                            bpos_next = length_reg[BPOS_W-1:0];
                            addr_next = length_reg[BPOS_W +: WIDX_W];
                            if (full)
                                status_next = STAT_SAT;
                            else
                                length_next = length_reg + LEN_W'(1);
                        end
                        OP_RESIZE:
                        begin
                            if (req.amount > LEN_W'(BOUND_BITS))
                            begin
                                length_next = LEN_W'(BOUND_BITS);
                                status_next = STAT_SAT;
                            end
                            else
                            begin
                                length_next = req.amount;
                            end
                        end
                        OP_OR, OP_AND, OP_XOR:
                        begin
                            addr_next = req.word_index;
                            if (word_bad)
                                status_next = STAT_RANGE;
                        end
                        OP_READ:
                        begin
                            if (!widx_ok)
                                status_next = STAT_RANGE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MODIFY:
            begin
                if (op_reg == OP_TEST)
                    bit_out_next = rd_bit;
            end
            S_SWEEP:
                cnt_next = cnt_reg + WIDX_W'(1);
            S_SHIFT:
                cnt_next = cnt_reg - WIDX_W'(1);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            length_reg  <= '0;
            status_reg  <= STAT_OK;
            bit_out_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            length_reg  <= length_next;
            status_reg  <= status_next;
            bit_out_reg <= bit_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        bpos_reg   <= bpos_next;
        bval_reg   <= bval_next;
        addr_reg   <= addr_next;
        amount_reg <= amount_next;
        widx_reg   <= widx_next;
        wval_reg   <= wval_next;
        minlen_reg <= minlen_next;
    end

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LEN_W'(BOUND_BITS))
        else $error("length beyond bound");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted beat left sequencer idle");

    a_shift_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && cnt_reg != '0) |=>
            (state_reg == S_SHIFT && cnt_reg == $past(cnt_reg) - WIDX_W'(1)))
        else $error("shift walk broken");

    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP && cnt_reg == WIDX_W'(WORD_COUNT-1)) |=>
            (state_reg == S_RESULT))
        else $error("sweep did not finish on last word");

endmodule

/* design/bit_vector_engine.sv */
// Top level of the bit vector engine: sequencer, shared word unit, word store and result register.
//
// One request beat on req carries one operation on a bit vector of up to 1024 bits held
// as sixteen 64-bit words; each request gives exactly one response beat on rsp.
// req.ready is high only while the sequencer is idle; one request is worked at a time.
// Sequencer states from request beat to the registered response, each path ending in RESULT:
//   out-of-range, saturated append, read word, unused op : RESULT directly
//   write, flip, test, append, OR/AND/XOR word           : MODIFY
//   set, clear, flip all, resize                         : SWEEP (one store word per cycle)
//   shift                                                : PRIME (priming read), SHIFT (16 words)
// The next request is taken the cycle after the response is loaded.
// The word store has a single read and a single write port, which sets the sweep length.
// Reset clears the store, the length and the response valid flag.
// A stalled rsp holds its beat; the block may take one further request meanwhile
// and keeps its result until the response register frees.
module bit_vector_engine
    import bve_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bve_req_if.sink   req,
    bve_rsp_if.source rsp
);

    store_ctl_t           sctl;
    alu_ctl_t             actl;
    res_t                 res;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_bit;
    logic                 out_free;

    logic                 valid_reg, valid_next;
    logic                 bit_out_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [LEN_W-1:0]     length_reg;
    logic [STAT_W-1:0]    status_reg;

    bve_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .rd_bit   (rd_bit),
        .sctl     (sctl),
        .actl     (actl),
        .res      (res)
    );

    bve_alu u_alu (
        .clk     (clk),
        .ctl     (actl),
        .rd_word (rd_data),
        .wr_word (wr_data),
        .rd_bit  (rd_bit)
    );

    bve_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sctl),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign out_free = !valid_reg || rsp.ready;

    always_comb
    begin
        priority if (res.load)
            valid_next = 1'b1;
        else if (rsp.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            bit_out_reg <= res.bit_out;
            word_reg    <= res.word_ok ? rd_data : '0;
            length_reg  <= res.length;
            status_reg  <= res.status;
        end
    end

    assign rsp.valid      = valid_reg;
    assign rsp.bit_out    = bit_out_reg;
    assign rsp.word_out   = word_reg;
    assign rsp.length_out = length_reg;
    assign rsp.status     = status_reg;

endmodule

/* test/bve_checker.sv */
`timescale 1ns / 1ps
// Checker for the bit vector engine: watches both channels, predicts each result and compares it.
module bve_checker
    import bve_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bve_req_if               req,
    bve_rsp_if               rsp,
    output int               fail_count,
    output int               pending_count,
    output logic [LEN_W-1:0] vec_length
);

    typedef struct packed {
        logic                 bit_out;
        logic [WORD_BITS-1:0] word;
        logic [LEN_W-1:0]     length;
        logic [STAT_W-1:0]    status;
    } bve_result_t;

    logic [BOUND_BITS-1:0] vec_bits;
    int unsigned           vec_len;
    bve_result_t           result_q[$];
    int                    errors = 0;

    function automatic logic [BOUND_BITS-1:0] below_mask(int unsigned n);
        if (n >= BOUND_BITS)
            return '1;
        return ({{(BOUND_BITS-1){1'b0}}, 1'b1} << n) - 1'b1;
    endfunction

    function automatic bve_result_t apply_op(logic [OP_W-1:0]      op,
                                             logic [BIDX_W-1:0]    bidx,
                                             logic                 bval,
                                             logic [LEN_W-1:0]     amount,
                                             logic [WIDX_W-1:0]    widx,
                                             logic [WORD_BITS-1:0] wval,
                                             logic [LEN_W-1:0]     olen);
        bve_result_t           res;
        int unsigned           new_len;
        int unsigned           common;
        int unsigned           base;
        logic [BOUND_BITS-1:0] m;
        logic [WORD_BITS-1:0]  wm;
        res        = '0;
        res.status = STAT_OK;
        base       = int'(widx) * WORD_BITS;
        case (op)
            OP_WRITE, OP_FLIP, OP_TEST:
            begin
                if (bidx >= vec_len)
                    res.status = STAT_RANGE;
                else if (op == OP_WRITE)
                    vec_bits[bidx] = bval;
                else if (op == OP_FLIP)
                    vec_bits[bidx] = ~vec_bits[bidx];
                else
                    res.bit_out = vec_bits[bidx];
            end
            OP_SET_ALL:  vec_bits = below_mask(vec_len);
            OP_CLR_ALL:  vec_bits = '0;
            OP_FLIP_ALL: vec_bits = ~vec_bits & below_mask(vec_len);
            OP_SHIFT:
            begin
                new_len = vec_len + amount;
                if (new_len > BOUND_BITS)
                begin
                    new_len    = BOUND_BITS;
                    res.status = STAT_SAT;
                end
                vec_bits = (vec_bits << amount) & below_mask(new_len);
                vec_len  = new_len;
            end
            OP_APPEND:
            begin
                if (vec_len >= BOUND_BITS)
                    res.status = STAT_SAT;
                else
                begin
                    vec_bits[vec_len] = bval;
                    vec_len++;
                end
            end
            OP_RESIZE:
            begin
                new_len = amount;
                if (new_len > BOUND_BITS)
                begin
                    new_len    = BOUND_BITS;
                    res.status = STAT_SAT;
                end
                vec_len  = new_len;
                vec_bits = vec_bits & below_mask(vec_len);
            end
            OP_OR, OP_AND, OP_XOR:
            begin
                common = (vec_len < olen) ? vec_len : olen;
                if (widx >= WORD_COUNT || base >= vec_len)
                    res.status = STAT_RANGE;
                else
                begin
                    m  = below_mask(common);
                    wm = m[base +: WORD_BITS];
                    if (op == OP_OR)
                        vec_bits[base +: WORD_BITS] |= wval & wm;
                    else if (op == OP_AND)
                        vec_bits[base +: WORD_BITS] &= wval | ~wm;
                    else
                        vec_bits[base +: WORD_BITS] ^= wval & wm;
                end
            end
            OP_READ:
            begin
                if (widx >= WORD_COUNT)
                    res.status = STAT_RANGE;
            end
            default: ;
        endcase
        res.word   = (widx < WORD_COUNT) ? vec_bits[base +: WORD_BITS] : '0;
        res.length = LEN_W'(vec_len);
        return res;
    endfunction

    task automatic flag_field(string name, logic [WORD_BITS-1:0] want,
                              logic [WORD_BITS-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bve_result_t want;
        if (!rst_n)
        begin
            vec_bits = '0;
            vec_len  = 0;
            result_q.delete();
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (result_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response beat: expected none, actual %h %h %h %h",
                             $time, rsp.bit_out, rsp.word_out, rsp.length_out, rsp.status);
                end
                else
                begin
                    want = result_q.pop_front();
                    flag_field("bit_out", want.bit_out, rsp.bit_out);
                    flag_field("word_out", want.word, rsp.word_out);
                    flag_field("length_out", want.length, rsp.length_out);
                    flag_field("status", want.status, rsp.status);
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                result_q.insert(result_q.size(),
                                apply_op(req.op, req.bit_index, req.bit_value, req.amount,
                                         req.word_index, req.word_value, req.other_length));
        end
        fail_count    <= errors;
        pending_count <= result_q.size();
        vec_length    <= LEN_W'(vec_len);
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the bit vector engine: clock, reset, request and response drivers, verdict.
module tb_top;
    import bve_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = '1;

    logic             clk;
    logic             rst_n;
    int               fail_count;
    int               pending_count;
    logic [LEN_W-1:0] model_len;
    int               hold_tag;
    logic             steady;

    bve_req_if req_ch ();
    bve_rsp_if rsp_ch ();

    bit_vector_engine DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bve_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .vec_length    (model_len)
    );

    initial
        clk = 1'b0;

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // response side: random stalls, a steady stretch, and one long hold-off
    initial
    begin : rsp_drive
        int seen_tag;
        int k;
        seen_tag = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_tag != seen_tag)
            begin
                seen_tag = hold_tag;
                rsp_ch.ready <= 1'b0;
                for (k = 0; k < 300; k++)
                    @(posedge clk);
            end
            rsp_ch.ready <= steady || ($urandom_range(99) >= 17);
        end
    end

    task automatic issue_op(logic [OP_W-1:0]      op,
                            logic [BIDX_W-1:0]    bidx,
                            logic                 bval,
                            logic [LEN_W-1:0]     amount,
                            logic [WIDX_W-1:0]    widx,
                            logic [WORD_BITS-1:0] wval,
                            logic [LEN_W-1:0]     olen);
        if (!steady && $urandom_range(99) < 17)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.bit_index    <= bidx;
        req_ch.bit_value    <= bval;
        req_ch.amount       <= amount;
        req_ch.word_index   <= widx;
        req_ch.word_value   <= wval;
        req_ch.other_length <= olen;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic issue_random();
        logic [OP_W-1:0]  op;
        logic [BIDX_W-1:0] bidx;
        logic [LEN_W-1:0] amount;
        logic [LEN_W-1:0] olen;
        logic [WIDX_W-1:0] widx;
        int               pick;
        int               len;
        len    = int'(model_len);
        pick   = int'($urandom_range(99));
        bidx   = BIDX_W'($urandom);
        amount = LEN_W'($urandom);
        widx   = WIDX_W'($urandom);
        olen   = LEN_W'($urandom);
        if (pick < 30)
        begin
            op = OP_W'($urandom_range(OP_WRITE, OP_TEST));
            if (len > 0 && $urandom_range(3) != 0)
                bidx = BIDX_W'($urandom_range(0, len - 1));
        end
        else if (pick < 38)
            op = OP_W'($urandom_range(OP_SET_ALL, OP_FLIP_ALL));
        else if (pick < 46)
        begin
            op = OP_SHIFT;
            if ($urandom_range(5) != 0)
                amount = LEN_W'($urandom_range(0, 40));
        end
        else if (pick < 58)
            op = OP_APPEND;
        else if (pick < 66)
        begin
            op = OP_RESIZE;
            if ($urandom_range(7) != 0)
                amount = LEN_W'($urandom_range(0, BOUND_BITS));
        end
        else if (pick < 88)
        begin
            op = OP_W'($urandom_range(OP_OR, OP_XOR));
            if (len > 0 && $urandom_range(3) != 0)
                widx = WIDX_W'($urandom_range(0, (len - 1) / WORD_BITS));
            if ($urandom_range(3) != 0)
                olen = LEN_W'($urandom_range(0, BOUND_BITS));
        end
        else if (pick < 97)
            op = OP_READ;
        else
            op = OP_W'($urandom_range(int'(OP_READ) + 1, int'(OP_SPARE)));
        issue_op(op, bidx, 1'($urandom), amount, widx, {$urandom, $urandom}, olen);
    endtask

    initial
    begin : stimulus
        int n;
        rst_n               <= 1'b0;
        steady              <= 1'b0;
        hold_tag            <= 0;
        req_ch.valid        <= 1'b0;
        req_ch.op           <= OP_READ;
        req_ch.bit_index    <= '0;
        req_ch.bit_value    <= 1'b0;
        req_ch.amount       <= '0;
        req_ch.word_index   <= '0;
        req_ch.word_value   <= '0;
        req_ch.other_length <= '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty vector, full vector, saturation and word-op edges
        issue_op(OP_TEST,     0,    0, 0,    0,  '0,             0);
        issue_op(OP_APPEND,   0,    1, 0,    0,  '0,             0);
        issue_op(OP_READ,     0,    0, 0,    0,  '0,             0);
        issue_op(OP_RESIZE,   0,    0, '1,   0,  '0,             0);
        issue_op(OP_SET_ALL,  0,    0, 0,    15, '0,             0);
        issue_op(OP_TEST,     1023, 0, 0,    15, '0,             0);
        issue_op(OP_WRITE,    1023, 0, 0,    15, '0,             0);
        issue_op(OP_FLIP,     0,    0, 0,    0,  '0,             0);
        issue_op(OP_READ,     0,    0, 0,    15, '0,             0);
        issue_op(OP_FLIP_ALL, 0,    0, 0,    0,  '0,             0);
        issue_op(OP_OR,       0,    0, 0,    15, '1,             '1);
        issue_op(OP_AND,      0,    0, 0,    0,  '0,             BOUND_BITS);
        issue_op(OP_XOR,      0,    0, 0,    7,  {32{2'b01}},    500);
        issue_op(OP_APPEND,   0,    1, 0,    0,  '0,             0);
        issue_op(OP_SHIFT,    0,    0, 0,    0,  '0,             0);
        issue_op(OP_SHIFT,    0,    0, 1,    15, '0,             0);
        issue_op(OP_CLR_ALL,  0,    0, 0,    15, '0,             0);
        issue_op(OP_RESIZE,   0,    0, 0,    0,  '0,             0);
        issue_op(OP_SHIFT,    0,    0, '1,   15, '0,             0);
        issue_op(OP_RESIZE,   0,    0, 100,  1,  '0,             0);
        issue_op(OP_SET_ALL,  0,    0, 0,    1,  '0,             0);
        issue_op(OP_SHIFT,    0,    0, 30,   2,  '0,             0);
        issue_op(OP_OR,       0,    0, 0,    3,  '1,             '1);
        issue_op(OP_XOR,      0,    0, 0,    2,  '1,             0);
        issue_op(OP_SPARE,    1023, 1, '1,   2,  '1,             '1);

        for (n = 0; n < 800; n++)
        begin
            if (n == 200)
                steady <= 1'b1;
            if (n == 350)
                steady <= 1'b0;
            if (n == 450)
                hold_tag <= hold_tag + 1;
            if (n == 600)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending_count != 0)
                    @(posedge clk);
            end
            issue_random();
        end
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (25)
            @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
design/bve_pkg.sv
design/bve_req_if.sv
design/bve_rsp_if.sv
design/bve_store.sv
design/bve_alu.sv
design/bve_seq.sv
design/bit_vector_engine.sv
test/bve_checker.sv
test/tb_top.sv
